// File: hdl/caa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// caa_pkg: shared definitions of the 8-bit CPU ALU
// Operation codes, field widths, flag positions and the request and
// response records that travel between the ALU core and the top level.
// ----------------------------------------------------------------------------
package caa_pkg;

  localparam int unsigned OP_W    = 6;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIDX_W  = 3;
  localparam int unsigned FLAGS_W = 4;

  // Flag positions inside the four-bit flag field.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants.
  localparam logic [BYTE_W-1:0] DAA_LO_ADJ = 8'h06;
  localparam logic [BYTE_W-1:0] DAA_HI_ADJ = 8'h60;
  localparam logic [BYTE_W-1:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0]        DAA_LO_LIM = 4'd9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 6'd0,
    OP_ADC    = 6'd1,
    OP_SUB    = 6'd2,
    OP_SBC    = 6'd3,
    OP_AND    = 6'd4,
    OP_XOR    = 6'd5,
    OP_OR     = 6'd6,
    OP_CP     = 6'd7,
    OP_INC    = 6'd8,
    OP_DEC    = 6'd9,
    OP_RLC    = 6'd10,
    OP_RRC    = 6'd11,
    OP_RL     = 6'd12,
    OP_RR     = 6'd13,
    OP_SLA    = 6'd14,
    OP_SRA    = 6'd15,
    OP_SWAP   = 6'd16,
    OP_SRL    = 6'd17,
    OP_BIT    = 6'd18,
    OP_RES    = 6'd19,
    OP_SET    = 6'd20,
    OP_DAA    = 6'd21,
    OP_CPL    = 6'd22,
    OP_CCF    = 6'd23,
    OP_SCF    = 6'd24,
    OP_RLCA   = 6'd25,
    OP_RLA    = 6'd26,
    OP_RRCA   = 6'd27,
    OP_RRA    = 6'd28,
    OP_ADD16  = 6'd29,
    OP_ADDSP  = 6'd30,
    OP_INC16  = 6'd31,
    OP_DEC16  = 6'd32
  } alu_op_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [WORD_W-1:0]  operand_a;
    logic [WORD_W-1:0]  operand_b;
    logic [BIDX_W-1:0]  bit_index;
    logic [FLAGS_W-1:0] flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  result;
    logic [FLAGS_W-1:0] flags_out;
    logic               writes_result;
  } alu_rsp_t;

endpackage
`default_nettype wire

// File: hdl/caa_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// caa_intf: request and response channels of the ALU
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface caa_req_if;
  import caa_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [WORD_W-1:0]  operand_a;
  logic [WORD_W-1:0]  operand_b;
  logic [BIDX_W-1:0]  bit_index;
  logic [FLAGS_W-1:0] flags_in;

  modport source (output valid, op, operand_a, operand_b, bit_index, flags_in,
                  input ready);
  modport sink   (input valid, op, operand_a, operand_b, bit_index, flags_in,
                  output ready);
endinterface

interface caa_rsp_if;
  import caa_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  result;
  logic [FLAGS_W-1:0] flags_out;
  logic               writes_result;

  modport source (output valid, result, flags_out, writes_result, input ready);
  modport sink   (input valid, result, flags_out, writes_result, output ready);
endinterface
`default_nettype wire

// File: hdl/caa_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// caa_alu: combinational ALU core
// Computes the result, the new flags and the write-back enable of one
// operation.
// ----------------------------------------------------------------------------
module caa_alu (
  input  caa_pkg::alu_req_t req_i,
  output caa_pkg::alu_rsp_t rsp_o
);
  import caa_pkg::*;

  logic [BYTE_W-1:0] a, b, bmask, adj;
  logic [WORD_W-1:0] a16, b16;
  logic              zin, nin, hin, cin;
  logic              z, n, h, c, wr;
  logic [WORD_W-1:0] res;
  logic [BYTE_W-1:0] r8;
  logic              carry_t;
  logic [BYTE_W:0]   sum9, diff9;
  logic [4:0]        nib5;
  logic [12:0]       sum13;
  logic [WORD_W:0]   sum17;

  assign a16 = req_i.operand_a;
  assign b16 = req_i.operand_b;
  assign a   = a16[BYTE_W-1:0];
  assign b   = b16[BYTE_W-1:0];
  assign zin = req_i.flags_in[FLAG_Z];
  assign nin = req_i.flags_in[FLAG_N];
  assign hin = req_i.flags_in[FLAG_H];
  assign cin = req_i.flags_in[FLAG_C];
  assign bmask = BYTE_W'(1) << req_i.bit_index;

  always_comb begin
    res     = {8'h00, a};
    r8      = a;
    z       = zin;
    n       = nin;
    h       = hin;
    c       = cin;
    wr      = 1'b1;
    carry_t = 1'b0;
    sum9    = '0;
    diff9   = '0;
    nib5    = '0;
    sum13   = '0;
    sum17   = '0;
    adj     = '0;

    unique case (req_i.op) inside
      OP_ADD, OP_ADC: begin
        carry_t = (req_i.op == OP_ADC) && cin;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, carry_t};
        nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, carry_t};
        r8 = sum9[BYTE_W-1:0];
        z = (r8 == '0);
        n = 1'b0;
        h = nib5[4];
        c = sum9[BYTE_W];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        carry_t = (req_i.op == OP_SBC) && cin;
        diff9 = {1'b0, a} - {1'b0, b} - {8'h00, carry_t};
        nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, carry_t};
        r8 = diff9[BYTE_W-1:0];
        z = (r8 == '0);
        n = 1'b1;
        h = nib5[4];
        c = diff9[BYTE_W];
        if (req_i.op == OP_CP) begin
          r8 = a;
          wr = 1'b0;
        end
      end
      OP_AND: begin
        r8 = a & b;
        z = (r8 == '0); n = 1'b0; h = 1'b1; c = 1'b0;
      end
      OP_XOR: begin
        r8 = a ^ b;
        z = (r8 == '0); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_OR: begin
        r8 = a | b;
        z = (r8 == '0); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_INC: begin
        r8 = a + 8'd1;
        z = (r8 == '0); n = 1'b0; h = (a[3:0] == 4'hF);
      end
      OP_DEC: begin
        r8 = a - 8'd1;
        z = (r8 == '0); n = 1'b1; h = (a[3:0] == 4'h0);
      end
      OP_RLC, OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        z = (req_i.op == OP_RLC) && (r8 == '0); n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_RRC, OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        z = (req_i.op == OP_RRC) && (r8 == '0); n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_RL, OP_RLA: begin
        r8 = {a[6:0], cin};
        z = (req_i.op == OP_RL) && (r8 == '0); n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_RR, OP_RRA: begin
        r8 = {cin, a[7:1]};
        z = (req_i.op == OP_RR) && (r8 == '0); n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        z = (r8 == '0); n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_SRA: begin
        r8 = {a[7], a[7:1]};
        z = (r8 == '0); n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        z = (r8 == '0); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        z = (r8 == '0); n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_BIT: begin
        z = ((a & bmask) == '0); n = 1'b0; h = 1'b1;
        wr = 1'b0;
      end
      OP_RES: r8 = a & ~bmask;
      OP_SET: r8 = a | bmask;
      OP_DAA: begin
        if (hin || (!nin && (a[3:0] > DAA_LO_LIM))) adj = adj | DAA_LO_ADJ;
        if (cin || (!nin && (a > DAA_HI_LIM))) begin
          adj = adj | DAA_HI_ADJ;
          c = 1'b1;
        end
        r8 = nin ? (a - adj) : (a + adj);
        z = (r8 == '0); h = 1'b0;
      end
      OP_CPL: begin
        r8 = ~a;
        n = 1'b1; h = 1'b1;
      end
      OP_CCF: begin
        n = 1'b0; h = 1'b0; c = !cin; wr = 1'b0;
      end
      OP_SCF: begin
        n = 1'b0; h = 1'b0; c = 1'b1; wr = 1'b0;
      end
      default: ;
    endcase

    res = {8'h00, r8};

    unique case (req_i.op) inside
      OP_ADD16: begin
        sum17 = {1'b0, a16} + {1'b0, b16};
        sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        res = sum17[WORD_W-1:0];
        n = 1'b0; h = sum13[12]; c = sum17[WORD_W];
      end
      OP_ADDSP: begin
        res = a16 + {{8{b[7]}}, b};
        sum9 = {1'b0, a} + {1'b0, b};
        nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        z = 1'b0; n = 1'b0; h = nib5[4]; c = sum9[BYTE_W];
      end
      OP_INC16: res = a16 + 16'd1;
      OP_DEC16: res = a16 - 16'd1;
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR, OP_CP, OP_INC,
      OP_DEC, OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
      OP_BIT, OP_RES, OP_SET, OP_DAA, OP_CPL, OP_CCF, OP_SCF, OP_RLCA, OP_RLA,
      OP_RRCA, OP_RRA: ;
      default: begin
        // Codes without an operation pass operand_a and the flags through.
        res = a16;
        wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_o.result         = res;
    rsp_o.flags_out      = '0;
    rsp_o.flags_out[FLAG_Z] = z;
    rsp_o.flags_out[FLAG_N] = n;
    rsp_o.flags_out[FLAG_H] = h;
    rsp_o.flags_out[FLAG_C] = c;
    rsp_o.writes_result  = wr;
  end

endmodule
`default_nettype wire

// File: hdl/cpu_alu_with_flags_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_top: 8-bit CPU execute unit with flags
// Registered ALU with valid/ready request and response channels.
// ----------------------------------------------------------------------------
// Each request transaction carries an operation code, two operands, a bit
// index and the incoming Z/N/H/C flags, and produces exactly one response
// transaction with the result, the new flags and the write-back enable, in
// request order. A request is captured into an input register, evaluated by
// the combinational ALU core and stored in the output register, from which
// the response is taken. Both stages advance whenever the stage behind them
// is empty or being drained, which gives a sustained rate of one transaction
// per clock cycle while the response is not stalled; a stalled response holds
// both stages and then deasserts the request ready. The 8-bit operations use
// the low byte of each operand and return a result whose high byte is zero;
// add16, add_sp_offset, inc16 and dec16 work on the full 16-bit operand_a.
// Unused operation codes return operand_a with the flags unchanged and no
// write-back. The block keeps no architectural state.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  caa_req_if.sink      req_i,
  caa_rsp_if.source    rsp_o
);
  import caa_pkg::*;

  logic     in_valid_q, in_valid_d;
  logic     out_valid_q, out_valid_d;
  alu_req_t in_q;
  alu_rsp_t out_q;
  alu_rsp_t alu_rsp;
  logic     out_stage_ready;
  logic     in_stage_ready;

  // A stage may load when it is empty or its content moves on this cycle.
  assign out_stage_ready = !out_valid_q || rsp_o.ready;
  assign in_stage_ready  = !in_valid_q || out_stage_ready;
  assign req_i.ready     = in_stage_ready;

  assign in_valid_d  = in_stage_ready ? req_i.valid : in_valid_q;
  assign out_valid_d = out_stage_ready ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only with a transaction and need no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_stage_ready) begin
      in_q.op        <= req_i.op;
      in_q.operand_a <= req_i.operand_a;
      in_q.operand_b <= req_i.operand_b;
      in_q.bit_index <= req_i.bit_index;
      in_q.flags_in  <= req_i.flags_in;
    end
  end

  caa_alu u_alu (
    .req_i (in_q),
    .rsp_o (alu_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_q && out_stage_ready) begin
      out_q <= alu_rsp;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result        = out_q.result;
  assign rsp_o.flags_out     = out_q.flags_out;
  assign rsp_o.writes_result = out_q.writes_result;

endmodule
`default_nettype wire
